// ===== rtl/windowed_sign_entropy_unit_assert.svh =====
// Assertion macros used by windowed_sign_entropy_unit. They expect clk and rst in scope.
`ifndef WINDOWED_SIGN_ENTROPY_UNIT_ASSERT_SVH
`define WINDOWED_SIGN_ENTROPY_UNIT_ASSERT_SVH

// Same-cycle implication.
`define WSE_ASSERT_IMP(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("windowed_sign_entropy_unit: same-cycle check failed");

// Next-cycle implication.
`define WSE_ASSERT_NXT(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("windowed_sign_entropy_unit: next-cycle check failed");

`endif

// ===== rtl/wse_pkg.sv =====
`timescale 1ns / 1ps
package wse_pkg;

  localparam int WIN_MAX   = 255;
  localparam int DEPTH     = WIN_MAX + 1;
  localparam int SEEN_CAP  = WIN_MAX + 2;
  localparam int PRICE_W   = 32;
  localparam int FRAC_BITS = 30;
  localparam int WLEN_W    = 8;
  localparam int PTR_W     = 8;
  localparam int CNT_W     = 9;
  localparam int LN_W      = 33;
  localparam int CLN_W     = 42;
  localparam int SUM_W     = 44;
  localparam int ENT_W     = 31;
  localparam int DIVCNT_W  = 6;
  localparam int LOG2_FRAC = 44;

  localparam logic [WLEN_W-1:0] WINDOW_RESET = WLEN_W'(200);
  localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AC;

  localparam logic [1:0] SGN_FLAT = 2'd0;
  localparam logic [1:0] SGN_UP   = 2'd1;
  localparam logic [1:0] SGN_DOWN = 2'd2;

  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] addr;
    logic [1:0]       data;
  } ring_wr_t;

  typedef logic [LN_W-1:0]  ln_tab_t  [0:DEPTH];
  typedef logic [CLN_W-1:0] cln_tab_t [0:DEPTH];

  // Bitwise log2 by repeated squaring of the mantissa, scaled by ln 2 and
  // rounded half up to FRAC_BITS fraction bits.
  function automatic logic [LN_W-1:0] ln_fixed(input int unsigned x);
    logic [63:0]  m;
    logic [63:0]  acc;
    logic [127:0] p;
    logic [63:0]  hi;
    logic [63:0]  r;
    int           e;
    e = 0;
    for (int i = 0; i < 31; i++) begin
      if ((x >> (i + 1)) != 0) e = i + 1;
    end
    m = 64'(x) << (31 - e);
    acc = 64'(e) << LOG2_FRAC;
    for (int k = LOG2_FRAC - 1; k >= 0; k--) begin
      m = (m * m) >> 31;
      if (m[63:32] != 32'd0) begin
        m = m >> 1;
        acc[k] = 1'b1;
      end
    end
    p = {64'd0, acc} * {64'd0, LN2_Q64};
    hi = p[127:64];
    r = ((hi >> (43 - FRAC_BITS)) + 64'd1) >> 1;
    return LN_W'(r);
  endfunction

  function automatic ln_tab_t build_ln();
    ln_tab_t t;
    t[0] = '0;
    for (int c = 1; c <= DEPTH; c++) t[c] = ln_fixed(c);
    return t;
  endfunction

  function automatic cln_tab_t build_cln();
    cln_tab_t    t;
    logic [63:0] v;
    t[0] = '0;
    for (int c = 1; c <= DEPTH; c++) begin
      v = 64'(c) * 64'(ln_fixed(c));
      t[c] = CLN_W'(v);
    end
    return t;
  endfunction

  localparam ln_tab_t  LN_TAB  = build_ln();
  localparam cln_tab_t CLN_TAB = build_cln();

endpackage

// ===== rtl/wse_channels.sv =====
`timescale 1ns / 1ps
interface wse_price_if;
  logic                      valid;
  logic                      ready;
  logic [wse_pkg::PRICE_W-1:0] close_price;
  modport source(output valid, output close_price, input ready);
  modport sink(input valid, input close_price, output ready);
endinterface

interface wse_result_if;
  logic                      valid;
  logic                      ready;
  logic [wse_pkg::ENT_W-1:0] entropy;
  logic [wse_pkg::CNT_W-1:0] up_count;
  logic [wse_pkg::CNT_W-1:0] down_count;
  logic [wse_pkg::CNT_W-1:0] flat_count;
  modport source(output valid, output entropy, output up_count, output down_count,
                 output flat_count, input ready);
  modport sink(input valid, input entropy, input up_count, input down_count,
               input flat_count, output ready);
endinterface

interface wse_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [wse_pkg::WLEN_W-1:0] window_len;
  modport source(output valid, output window_len, input ready);
  modport sink(input valid, input window_len, output ready);
endinterface

// ===== rtl/wse_ring_ram.sv =====
`timescale 1ns / 1ps
module wse_ring_ram (
  input  logic                       clk,
  input  wse_pkg::ring_wr_t          wr,
  input  logic [wse_pkg::PTR_W-1:0]  raddr,
  output logic [1:0]                 rdata
);
  import wse_pkg::*;

  logic [1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/wse_div.sv =====
`timescale 1ns / 1ps
module wse_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [wse_pkg::SUM_W-1:0] dividend,
  input  logic [wse_pkg::CNT_W-1:0] divisor,
  output logic                      done,
  output logic [wse_pkg::SUM_W-1:0] quotient
);
  import wse_pkg::*;

  logic [CNT_W-1:0]    rem;
  logic [CNT_W-1:0]    dvs;
  logic [DIVCNT_W-1:0] cnt;
  logic                busy;
  logic [CNT_W:0]      shifted;
  logic                ge;

  // One quotient bit per cycle, restoring form.
  always_comb begin
    shifted = {rem, quotient[SUM_W-1]};
    ge = shifted >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIVCNT_W'(SUM_W);
      end else if (busy) begin
        cnt <= cnt - DIVCNT_W'(1);
        if (cnt == DIVCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      rem      <= ge ? CNT_W'(shifted - {1'b0, dvs}) : shifted[CNT_W-1:0];
      quotient <= {quotient[SUM_W-2:0], ge};
    end
  end
endmodule

// ===== rtl/windowed_sign_entropy_unit.sv =====
`timescale 1ns / 1ps
// A bar yielding a result passes S_UPD, S_SUM, S_DIVS, S_DIVW, S_OUT before output valid.
// No new bar is taken before S_IDLE; the serial divide of the c ln c sum sets the pace.
// Bars without a result (the first two) go through S_UPD and straight back to S_IDLE.
// Reset (synchronous, active high) sets window_len to 200 and clears price, tallies, pointer.
// A window_len write clears the same state; ring contents are never cleared.
module windowed_sign_entropy_unit (
  input logic          clk,
  input logic          rst,
  wse_price_if.sink    price,
  wse_result_if.source result,
  wse_cfg_if.sink      cfg
);
  import wse_pkg::*;
  `include "windowed_sign_entropy_unit_assert.svh"

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_DIVS = 3'd3;
  localparam logic [2:0] S_DIVW = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]         state;
  logic [WLEN_W-1:0]  window_len;
  logic [PRICE_W-1:0] prev_price;
  logic [PRICE_W-1:0] price_q;
  logic [PTR_W-1:0]   ptr;
  logic [CNT_W-1:0]   rise;
  logic [CNT_W-1:0]   fall;
  logic [CNT_W-1:0]   level;
  logic [CNT_W-1:0]   bars_seen;
  logic [CNT_W-1:0]   n_q;
  logic [SUM_W-1:0]   s_q;
  logic [LN_W-1:0]    lnn_q;
  logic               out_valid;
  logic [ENT_W-1:0]   ent_q;
  logic [CNT_W-1:0]   up_q;
  logic [CNT_W-1:0]   down_q;
  logic [CNT_W-1:0]   flat_q;

  logic               in_fire;
  logic               cfg_fire;
  logic               out_fire;
  logic [CNT_W-1:0]   span;
  logic [1:0]         sgn;
  logic [1:0]         old_sgn;
  logic               drop;
  logic [CNT_W-1:0]   rise_next;
  logic [CNT_W-1:0]   fall_next;
  logic [CNT_W-1:0]   level_next;
  logic [CNT_W-1:0]   bars_next;
  logic [PTR_W-1:0]   rd_addr;
  ring_wr_t           ring_wr;
  logic               div_done;
  logic [SUM_W-1:0]   quo;
  logic [SUM_W-1:0]   diff;

  assign in_fire  = price.valid && price.ready;
  assign cfg_fire = cfg.valid && cfg.ready;
  assign out_fire = result.valid && result.ready;

  assign cfg.ready   = (state == S_IDLE);
  assign price.ready = (state == S_IDLE) && !cfg.valid;

  always_comb begin
    span = CNT_W'(window_len) + CNT_W'(1);
    // The entry leaving the window sits span slots behind the write pointer.
    rd_addr = ptr - span[PTR_W-1:0];
    sgn = (price_q > prev_price) ? SGN_UP :
          (price_q < prev_price) ? SGN_DOWN : SGN_FLAT;
    drop = (bars_seen - CNT_W'(1)) >= span;
    rise_next = rise - CNT_W'(drop && old_sgn == SGN_UP && rise != '0)
                     + CNT_W'(sgn == SGN_UP);
    fall_next = fall - CNT_W'(drop && old_sgn == SGN_DOWN && fall != '0)
                     + CNT_W'(sgn == SGN_DOWN);
    level_next = level - CNT_W'(drop && old_sgn != SGN_UP && old_sgn != SGN_DOWN
                                && level != '0)
                       + CNT_W'(sgn == SGN_FLAT);
    bars_next = (bars_seen < CNT_W'(SEEN_CAP)) ? bars_seen + CNT_W'(1) : bars_seen;
    ring_wr.we   = (state == S_UPD) && (bars_seen != '0);
    ring_wr.addr = ptr;
    ring_wr.data = sgn;
    diff = ({{(SUM_W-LN_W){1'b0}}, lnn_q} > quo) ? {{(SUM_W-LN_W){1'b0}}, lnn_q} - quo : '0;
  end

  wse_ring_ram u_ring (
    .clk   (clk),
    .wr    (ring_wr),
    .raddr (rd_addr),
    .rdata (old_sgn)
  );

  wse_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_DIVS),
    .dividend (s_q),
    .divisor  (n_q),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      window_len <= WINDOW_RESET;
      prev_price <= '0;
      ptr        <= '0;
      rise       <= '0;
      fall       <= '0;
      level      <= '0;
      bars_seen  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_fire) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cfg_fire) begin
            window_len <= cfg.window_len;
            prev_price <= '0;
            ptr        <= '0;
            rise       <= '0;
            fall       <= '0;
            level      <= '0;
            bars_seen  <= '0;
          end else if (in_fire) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          prev_price <= price_q;
          if (bars_seen == '0) begin
            bars_seen <= CNT_W'(1);
            state     <= S_IDLE;
          end else begin
            rise      <= rise_next;
            fall      <= fall_next;
            level     <= level_next;
            ptr       <= ptr + PTR_W'(1);
            bars_seen <= bars_next;
            state     <= (bars_next < CNT_W'(3)) ? S_IDLE : S_SUM;
          end
        end
        S_SUM:  state <= S_DIVS;
        S_DIVS: state <= S_DIVW;
        S_DIVW: if (div_done) state <= S_OUT;
        S_OUT: begin
          if (!out_valid || result.ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) price_q <= price.close_price;
    if (state == S_SUM) begin
      n_q <= rise + fall + level;
      s_q <= SUM_W'(CLN_TAB[rise]) + SUM_W'(CLN_TAB[fall]) + SUM_W'(CLN_TAB[level]);
    end
    if (state == S_DIVS) lnn_q <= LN_TAB[n_q];
    // The tallies are copied so that a waiting word is not disturbed by the next bar.
    if (state == S_OUT && (!out_valid || result.ready)) begin
      ent_q  <= (diff > SUM_W'({ENT_W{1'b1}})) ? {ENT_W{1'b1}} : diff[ENT_W-1:0];
      up_q   <= rise;
      down_q <= fall;
      flat_q <= level;
    end
  end

  assign result.valid      = out_valid;
  assign result.entropy    = ent_q;
  assign result.up_count   = up_q;
  assign result.down_count = down_q;
  assign result.flat_count = flat_q;

  `WSE_ASSERT_NXT(a_accept_to_update, in_fire, state == S_UPD)
  `WSE_ASSERT_NXT(a_cfg_clears, cfg_fire, bars_seen == '0 && rise == '0)
  `WSE_ASSERT_IMP(a_window_bound, state == S_IDLE,
                  ({1'b0, rise} + {1'b0, fall} + {1'b0, level}) <= (CNT_W+1)'(DEPTH))
  `WSE_ASSERT_IMP(a_nonzero_divisor, state == S_DIVS, n_q != '0)
endmodule
